### hdl/smh_pkg.sv
// Shared types, constants and the constant multiplier for the string hash block.
package smh_pkg;

  localparam int unsigned HashWidth  = 64;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned FirstShift = 7;

  typedef logic [HashWidth-1:0]        hash_t;
  typedef logic signed [HashWidth-1:0] hash_s_t;
  typedef logic [ByteWidth-1:0]        byte_t;
  typedef logic [CountWidth-1:0]       count_t;

  localparam count_t CountMax = '1;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_HASH_PREFIX = 1'b0,
    REG_HASH_SUFFIX = 1'b1
  } cfg_reg_e;

  // Multiply by 1000003 = 2^20 - 2^16 + 2^14 + 2^9 + 2^6 + 2^2 - 1, modulo 2^64
  function automatic hash_t mul_hash_const(input hash_t h);
    hash_t acc;
    acc = (h << 20) - (h << 16) + (h << 14) + (h << 9) + (h << 6) + (h << 2) - h;
    return acc;
  endfunction

endpackage

### hdl/smh_if.sv
// Valid/ready channel interfaces for byte input, hash output and configuration writes.
interface smh_in_if;
  logic             valid;
  logic             ready;
  smh_pkg::byte_t   data_byte;
  logic             is_last;

  modport source (output valid, data_byte, is_last, input ready);
  modport sink   (input valid, data_byte, is_last, output ready);
endinterface

interface smh_out_if;
  logic              valid;
  logic              ready;
  smh_pkg::hash_s_t  hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

interface smh_cfg_if;
  logic              valid;
  logic              ready;
  smh_pkg::cfg_reg_e index;
  smh_pkg::hash_t    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/string_multiplicative_hash.sv
// Randomised multiplicative string hash: one byte per item, one result per string.
// Path: a string's last byte is held in the input register, and its result then
//   in the result register, where it stays while the output stalls.
// Throughput: one byte per cycle; the hash/count update is one constant multiply
//   and XOR per cycle. A stalled result blocks only a following last byte, and the bytes behind it.
// Reset: asynchronous, active low; clears the running hash, byte count,
//   prefix, suffix and all valid flags.
module string_multiplicative_hash (
  input  logic      clk_i,
  input  logic      rst_ni,
  smh_in_if.sink    byte_i,
  smh_out_if.source hash_o,
  smh_cfg_if.sink   cfg_i
);
  import smh_pkg::*;

  hash_t  prefix_q, suffix_q;
  hash_t  run_q;
  count_t cnt_q;

  logic   item_vld_q;
  byte_t  item_byte_q;
  logic   item_last_q;

  logic   out_vld_q;
  hash_t  out_hash_q;

  logic   process;
  logic   first;
  hash_t  byte_ext;
  hash_t  h_base;
  hash_t  h_new;
  count_t cnt_inc;
  hash_t  result_d;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= '0;
      suffix_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_HASH_PREFIX: prefix_q <= cfg_i.data;
        REG_HASH_SUFFIX: suffix_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Only a last byte needs room in the result register
  assign process      = item_vld_q & (~item_last_q | ~out_vld_q | hash_o.ready);
  assign byte_i.ready = ~item_vld_q | process;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (byte_i.ready) begin
      item_vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      item_byte_q <= byte_i.data_byte;
      item_last_q <= byte_i.is_last;
    end
  end

  assign first    = (cnt_q == '0);
  assign byte_ext = HashWidth'(item_byte_q);
  assign h_base   = first ? (prefix_q ^ (byte_ext << FirstShift)) : run_q;
  assign h_new    = mul_hash_const(h_base) ^ byte_ext;
  assign cnt_inc  = (cnt_q == CountMax) ? cnt_q : cnt_q + count_t'(1);
  assign result_d = (first && item_last_q) ? byte_ext
                                           : (h_new ^ HashWidth'(cnt_inc) ^ suffix_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      cnt_q <= '0;
    end else if (process) begin
      if (item_last_q) begin
        run_q <= '0;
        cnt_q <= '0;
      end else begin
        run_q <= h_new;
        cnt_q <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (process && item_last_q) begin
      out_vld_q <= 1'b1;
    end else if (hash_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && item_last_q) begin
      out_hash_q <= result_d;
    end
  end

  assign hash_o.valid      = out_vld_q;
  assign hash_o.hash_value = $signed(out_hash_q);

endmodule

### hdl/smh_checker.sv
// Port-level checks for the string hash block, bound to its top level.
module smh_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input smh_pkg::hash_s_t    out_hash
);
  import smh_pkg::*;

  // A held result keeps its valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_hash))
    else $error("result changed while stalled");

  // With the result register empty, the input side never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Reset leaves no result pending
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("result valid during reset");

endmodule

bind string_multiplicative_hash smh_checker u_smh_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (byte_i.ready),
  .out_valid (hash_o.valid),
  .out_ready (hash_o.ready),
  .out_hash  (hash_o.hash_value)
);
